>>> rtl/qyaw_pkg.sv
// qyaw_pkg: shared widths, cordic step-angle table and the vector struct
// used by the quaternion yaw pipeline; no dependencies
package qyaw_pkg;

    localparam int COMP_W        = 16;   // quaternion component width
    localparam int PROD_W        = 2 * COMP_W;
    localparam int XW            = 36;   // cordic x/y width, holds 2^33.3 growth
    localparam int ZW            = 30;   // angle width, 1/65536 tenth of a degree
    localparam int ANG_W         = 25;   // width of one step angle
    localparam int YAW_W         = 12;
    localparam int CORDIC_STEPS  = 24;
    localparam int ANGLE_FRAC    = 16;
    localparam int TENTHS_TURN   = 3600;
    localparam int FRAC_BITS_DEF = 14;

    localparam logic signed [ZW-1:0] FULL_TURN = ZW'(TENTHS_TURN) <<< ANGLE_FRAC;
    localparam logic signed [ZW-1:0] HALF_TURN = FULL_TURN >>> 1;

    // atan(2^-n) in 1/65536 tenth of a degree, rounded
    localparam logic [ANG_W-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
        25'd29491200, 25'd17409672, 25'd9198793, 25'd4669451, 25'd2343786,
        25'd1173036,  25'd586661,   25'd293348,  25'd146676,  25'd73339,
        25'd36669,    25'd18335,    25'd9167,    25'd4584,    25'd2292,
        25'd1146,     25'd573,      25'd286,     25'd143,     25'd72,
        25'd36,       25'd18,       25'd9,       25'd4
    };

    // vector carried down the rotation pipeline
    typedef struct packed {
        logic                 zero;   // sy and cy both zero
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } qyaw_vec_t;

endpackage

>>> rtl/qyaw_front.sv
// qyaw_front: two register stages, component products then sy/cy with
// left half-plane fold; depends on qyaw_pkg
module qyaw_front
    import qyaw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [COMP_W-1:0] comp_i,
    input  logic signed [COMP_W-1:0] comp_j,
    input  logic signed [COMP_W-1:0] comp_k,
    input  logic signed [COMP_W-1:0] comp_real,
    output logic                     out_valid,
    output qyaw_vec_t                out_vec
);

    localparam logic signed [XW-1:0] ONE = XW'(1) <<< (2 * FRAC_BITS);

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] p_wk_reg, p_ij_reg, p_jj_reg, p_kk_reg;
    logic signed [PROD_W-1:0] p_wk_next, p_ij_next, p_jj_next, p_kk_next;

    logic                     vec_valid_reg;
    qyaw_vec_t                vec_reg, vec_next;

    logic signed [XW-1:0] e_wk, e_ij, e_jj, e_kk;
    logic signed [XW-1:0] sy, cy, n_sy, n_cy, sq2;

    assign p_wk_next = comp_real * comp_k;
    assign p_ij_next = comp_i * comp_j;
    assign p_jj_next = comp_j * comp_j;
    assign p_kk_next = comp_k * comp_k;

    always_comb
    begin
        e_wk = {{(XW-PROD_W){p_wk_reg[PROD_W-1]}}, p_wk_reg};
        e_ij = {{(XW-PROD_W){p_ij_reg[PROD_W-1]}}, p_ij_reg};
        e_jj = {{(XW-PROD_W){p_jj_reg[PROD_W-1]}}, p_jj_reg};
        e_kk = {{(XW-PROD_W){p_kk_reg[PROD_W-1]}}, p_kk_reg};
        sq2  = (e_jj + e_kk) <<< 1;
        sy   = (e_wk + e_ij) <<< 1;
        n_sy = -sy;
        cy   = ONE - sq2;
        n_cy = sq2 - ONE;
        vec_next.zero = (sy == '0) && (cy == '0);
        // left half plane: turn the vector by 180 degrees first
        if (cy[XW-1])
        begin
            vec_next.x = n_cy;
            vec_next.y = n_sy;
            vec_next.z = HALF_TURN;
        end
        else
        begin
            vec_next.x = cy;
            vec_next.y = sy;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            vec_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            vec_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_wk_reg <= p_wk_next;
        p_ij_reg <= p_ij_next;
        p_jj_reg <= p_jj_next;
        p_kk_reg <= p_kk_next;
        vec_reg  <= vec_next;
    end

    assign out_valid = vec_valid_reg;
    assign out_vec   = vec_reg;

endmodule

>>> rtl/qyaw_cordic_stage.sv
// qyaw_cordic_stage: one registered cordic vectoring step with a fixed
// shift; depends on qyaw_pkg
module qyaw_cordic_stage
    import qyaw_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  qyaw_vec_t in_vec,
    output logic      out_valid,
    output qyaw_vec_t out_vec
);

    localparam logic signed [ZW-1:0] ANG = ZW'(STEP_ANGLE[STEP]);

    logic                 valid_reg;
    qyaw_vec_t            vec_reg, vec_next;
    logic signed [XW-1:0] xs, ys;

    always_comb
    begin
        xs = in_vec.x >>> STEP;
        ys = in_vec.y >>> STEP;
        vec_next.zero = in_vec.zero;
        // y of exactly zero rotates as positive
        if (!in_vec.y[XW-1])
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ANG;
        end
        else
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

>>> rtl/qyaw_back.sv
// qyaw_back: two register stages, wrap into one turn then round to tenths
// with the 3600 fold; depends on qyaw_pkg
module qyaw_back
    import qyaw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_zero,
    input  logic signed [ZW-1:0] in_z,
    output logic                 out_valid,
    output logic [YAW_W-1:0]     yaw_tenths
);

    localparam logic [ZW-1:0]    HALF_LSB = ZW'(1) << (ANGLE_FRAC - 1);
    localparam logic [YAW_W:0]   TURN_T   = (YAW_W + 1)'(TENTHS_TURN);

    logic                 wrap_valid_reg;
    logic                 wrap_zero_reg;
    logic signed [ZW-1:0] wrap_z_reg, wrap_z_next;

    logic                 yaw_valid_reg;
    logic [YAW_W-1:0]     yaw_reg, yaw_next;
    logic [ZW-1:0]        rsum;
    logic [YAW_W:0]       tenths;

    // negative angle gets a full turn added; never below zero afterward
    assign wrap_z_next = in_z[ZW-1] ? in_z + FULL_TURN : in_z;

    always_comb
    begin
        rsum   = wrap_z_reg + HALF_LSB;
        tenths = rsum[ANGLE_FRAC +: (YAW_W + 1)];
        if (wrap_zero_reg)
            yaw_next = '0;
        else if (tenths >= TURN_T)
            yaw_next = YAW_W'(tenths - TURN_T);
        else
            yaw_next = tenths[YAW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_valid_reg <= 1'b0;
            yaw_valid_reg  <= 1'b0;
        end
        else
        begin
            wrap_valid_reg <= in_valid;
            yaw_valid_reg  <= wrap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wrap_z_reg    <= wrap_z_next;
        wrap_zero_reg <= in_zero;
        yaw_reg       <= yaw_next;
    end

    assign out_valid  = yaw_valid_reg;
    assign yaw_tenths = yaw_reg;

endmodule

>>> rtl/quaternion_to_yaw_tenths.sv
// quaternion_to_yaw_tenths: top level of the quaternion yaw pipeline
// uses qyaw_pkg, qyaw_front, qyaw_cordic_stage, qyaw_back
//
//  channel   handshake        payload
//  -------   --------------   ------------------------------------------
//  request   start / busy     comp_i, comp_j, comp_k, comp_real (s16)
//  result    done (strobe)    yaw_tenths (u12, 0..3599)
//
// a request is taken on every edge with start high; busy is never raised
// pipeline of 2 front stages (products, sy/cy and half-plane
// fold), 24 cordic stages with one shift-add step each, 2 back stages
// (wrap, round); the 24-step rotation chain sets the latency
// the receiver cannot stall, so the pipeline never holds; done pulses once
// per request, in request order
// reset clears the valid bits only; no result appears until a request enters
module quaternion_to_yaw_tenths
    import qyaw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COMP_W-1:0] comp_i,
    input  logic signed [COMP_W-1:0] comp_j,
    input  logic signed [COMP_W-1:0] comp_k,
    input  logic signed [COMP_W-1:0] comp_real,
    output logic                     done,
    output logic [YAW_W-1:0]         yaw_tenths
);

    // valid and vector at the entry of each cordic step, plus the exit
    logic      stage_valid [CORDIC_STEPS+1];
    qyaw_vec_t stage_vec   [CORDIC_STEPS+1];

    // fully pipelined: a new request is accepted every cycle
    assign busy = 1'b0;

    // products, then sy/cy with the left half plane folded over
    qyaw_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .comp_i    (comp_i),
        .comp_j    (comp_j),
        .comp_k    (comp_k),
        .comp_real (comp_real),
        .out_valid (stage_valid[0]),
        .out_vec   (stage_vec[0])
    );

    // unrolled rotation chain, one register stage per step
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        qyaw_cordic_stage #(
            .STEP (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_vec    (stage_vec[g]),
            .out_valid (stage_valid[g+1]),
            .out_vec   (stage_vec[g+1])
        );
    end

    // residual x/y are dropped here; only the accumulated angle and the zero flag go on
    qyaw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stage_valid[CORDIC_STEPS]),
        .in_zero    (stage_vec[CORDIC_STEPS].zero),
        .in_z       (stage_vec[CORDIC_STEPS].z),
        .out_valid  (done),
        .yaw_tenths (yaw_tenths)
    );

endmodule
